@@ rtl/bpc_pkg.sv @@
package bpc_pkg;

	// field and register widths
	localparam int TIMER_W = 16;
	localparam int COUNT_W = 4;
	localparam int KEY_W   = 2;

	// register reset values
	localparam logic [TIMER_W-1:0] SHORT_WINDOW_RESET = 16'd750;
	localparam logic [TIMER_W-1:0] LONG_HOLD_RESET    = 16'd4000;

	// press count saturates here
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

	// action codes
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_KEY  = 1'b1;

	// key event values (three is taken like repeat)
	localparam logic [KEY_W-1:0] KEY_UP     = 2'd0;
	localparam logic [KEY_W-1:0] KEY_DOWN   = 2'd1;
	localparam logic [KEY_W-1:0] KEY_REPEAT = 2'd2;

	// configuration register indexes
	localparam logic REG_SHORT_WINDOW = 1'b0;
	localparam logic REG_LONG_HOLD    = 1'b1;

	typedef enum logic [1:0] {
		GEST_NONE   = 2'd0,
		GEST_SHORT  = 2'd1,
		GEST_DOUBLE = 2'd2,
		GEST_LONG   = 2'd3
	} gesture_t;

	typedef struct packed {
		logic               short_running;
		logic [TIMER_W-1:0] short_remaining;
		logic               long_running;
		logic [TIMER_W-1:0] long_remaining;
		logic [KEY_W-1:0]   last_key_value;
		logic [COUNT_W-1:0] press_count;
	} press_state_t;

	// cleared press state: timers stopped, button up, no presses
	localparam press_state_t STATE_CLEAR = '0;

endpackage

@@ rtl/bpc_step.sv @@
module bpc_step (
	input  logic                           action,
	input  logic [bpc_pkg::KEY_W-1:0]      key_value,
	input  logic [bpc_pkg::TIMER_W-1:0]    short_window_ticks,
	input  logic [bpc_pkg::TIMER_W-1:0]    long_hold_ticks,
	input  bpc_pkg::press_state_t          cur,
	output bpc_pkg::press_state_t          nxt,
	output bpc_pkg::gesture_t              gesture
);
	import bpc_pkg::*;

	logic long_exp;
	logic short_exp;
	press_state_t ticked;

	// a running timer expires on the tick that finds it at one or zero
	assign long_exp  = cur.long_running  && (cur.long_remaining  <= 16'd1);
	assign short_exp = cur.short_running && (cur.short_remaining <= 16'd1);

	always_comb begin
		ticked = cur;
		if (cur.long_running) begin
			if (long_exp) begin
				ticked.long_running   = 1'b0;
				ticked.long_remaining = '0;
			end else begin
				ticked.long_remaining = cur.long_remaining - 16'd1;
			end
		end
		if (cur.short_running) begin
			if (short_exp) begin
				ticked.short_running   = 1'b0;
				ticked.short_remaining = '0;
			end else begin
				ticked.short_remaining = cur.short_remaining - 16'd1;
			end
		end
	end

	always_comb begin
		nxt     = cur;
		gesture = GEST_NONE;
		if (action == ACT_KEY) begin
			nxt.last_key_value = key_value;
			if (key_value == KEY_UP) begin
				nxt.long_running   = 1'b0;
				nxt.long_remaining = '0;
				if (!cur.short_running) begin
					nxt = STATE_CLEAR;
				end
			end else begin
				if (cur.press_count < COUNT_MAX) begin
					nxt.press_count = cur.press_count + 4'd1;
				end
				nxt.short_running   = 1'b1;
				nxt.short_remaining = short_window_ticks;
				nxt.long_running    = 1'b1;
				nxt.long_remaining  = long_hold_ticks;
			end
		end else begin
			nxt = ticked;
			priority if (long_exp) begin
				nxt     = STATE_CLEAR;
				gesture = GEST_LONG;
			end else if (short_exp && (cur.last_key_value != KEY_DOWN)) begin
				if (cur.press_count == 4'd1) begin
					gesture = GEST_SHORT;
				end else if (cur.press_count == 4'd2) begin
					gesture = GEST_DOUBLE;
				end
				nxt = STATE_CLEAR;
			end else begin
				// timers only count down
				gesture = GEST_NONE;
			end
		end
	end

endmodule

@@ rtl/button_press_classifier.sv @@
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tdata[0] action, tdata[2:1] key_value
// m_*       out  m_tvalid/m_tready  tdata[1:0] gesture
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One item per cycle sustained while m_tready stays high. An accepted item is
// registered in the input stage, where the press state is updated and the
// gesture computed in a single pass; the result register then holds the gesture.
// Each item gives exactly one result; key events always give gesture none.
// arst_n clears the press state, empties both stages and reloads the
// registers with 750 and 4000 ticks. A stall on m_tready holds the result and
// backs up into the input stage; s_tready drops only when both are full.
module button_press_classifier (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // action, key_value, zero pad
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,   // gesture, zero pad
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [bpc_pkg::TIMER_W-1:0]  cfg_data
);
	import bpc_pkg::*;

	// configuration
	logic [TIMER_W-1:0] short_window_q;
	logic [TIMER_W-1:0] long_hold_q;

	// input stage
	logic             valid_s1;
	logic             action_s1;
	logic [KEY_W-1:0] key_s1;

	// press state and result register
	press_state_t st_q;
	press_state_t st_nxt;
	gesture_t     gesture_nxt;
	gesture_t     gesture_q;
	logic         out_valid_q;

	logic advance;

	// the input stage moves on when the result register is empty or drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_window_q <= SHORT_WINDOW_RESET;
			long_hold_q    <= LONG_HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SHORT_WINDOW: short_window_q <= cfg_data;
				REG_LONG_HOLD:    long_hold_q    <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tdata[0];
			key_s1    <= s_tdata[2:1];
		end
	end

	bpc_step u_step (
		.action             (action_s1),
		.key_value          (key_s1),
		.short_window_ticks (short_window_q),
		.long_hold_ticks    (long_hold_q),
		.cur                (st_q),
		.nxt                (st_nxt),
		.gesture            (gesture_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= st_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			gesture_q <= gesture_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, gesture_q};

	// key events never report a gesture
	a_key_no_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_s1 == ACT_KEY) |=> (gesture_q == GEST_NONE))
		else $error("key event produced a gesture");

	// a long press leaves the press state cleared
	a_long_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && gesture_nxt == GEST_LONG) |=>
		(!st_q.long_running && !st_q.short_running && st_q.press_count == '0))
		else $error("long press did not clear state");

	// a stopped timer holds no leftover count
	a_long_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.long_running |-> (st_q.long_remaining == '0))
		else $error("stopped long timer has nonzero count");

	a_short_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.short_running |-> (st_q.short_remaining == '0))
		else $error("stopped short timer has nonzero count");

endmodule

@@ test/gesture_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams and the register port, predicts one gesture per
// accepted item and checks the results in order.
module gesture_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // action, key_value, zero pad
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [7:0]                  m_tdata,   // gesture, zero pad
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bpc_pkg::TIMER_W-1:0] cfg_data,
	output int                          gestures_pending,
	output int                          mismatch_count
);
	import bpc_pkg::*;

	// the block holds at most two items, so a small ring is plenty
	localparam int DUE_DEPTH = 16;

	press_state_t       press;
	logic [TIMER_W-1:0] short_window;
	logic [TIMER_W-1:0] long_hold;
	gesture_t           gestures_due [DUE_DEPTH];
	int                 due_head;
	int                 due_count;
	gesture_t           due;

	initial mismatch_count = 0;

	task automatic report_mismatch(input string what, input int want, input int got);
		$display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
		mismatch_count++;
	endtask

	// one tick on a timer; high when it runs out now
	function automatic logic run_timer(inout logic running, inout logic [TIMER_W-1:0] remaining);
		if (!running)
			return 1'b0;
		if (remaining <= 1) begin
			remaining = '0;
			running = 1'b0;
			return 1'b1;
		end
		remaining = remaining - 1'b1;
		return 1'b0;
	endfunction

	function automatic gesture_t classify_item(input logic act, input logic [KEY_W-1:0] key);
		gesture_t g;
		logic     long_out;
		logic     short_out;
		g = GEST_NONE;
		if (act == ACT_KEY) begin
			press.last_key_value = key;
			if (key == KEY_UP) begin
				press.long_running = 1'b0;
				press.long_remaining = '0;
				if (!press.short_running)
					press = STATE_CLEAR;
			end else begin
				if (press.press_count < COUNT_MAX)
					press.press_count = press.press_count + 1'b1;
				press.short_running = 1'b1;
				press.short_remaining = short_window;
				press.long_running = 1'b1;
				press.long_remaining = long_hold;
			end
		end else begin
			long_out = run_timer(press.long_running, press.long_remaining);
			short_out = run_timer(press.short_running, press.short_remaining);
			if (long_out) begin
				press = STATE_CLEAR;
				g = GEST_LONG;
			end else if (short_out && press.last_key_value != KEY_DOWN) begin
				if (press.press_count == 1)
					g = GEST_SHORT;
				else if (press.press_count == 2)
					g = GEST_DOUBLE;
				press = STATE_CLEAR;
			end
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press = STATE_CLEAR;
			short_window = SHORT_WINDOW_RESET;
			long_hold = LONG_HOLD_RESET;
			due_head = 0;
			due_count = 0;
			gestures_pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SHORT_WINDOW)
					short_window = cfg_data;
				else
					long_hold = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				gestures_due[(due_head + due_count) % DUE_DEPTH] =
					classify_item(s_tdata[0], s_tdata[2:1]);
				due_count++;
			end
			if (m_tvalid && m_tready) begin
				if (due_count == 0) begin
					report_mismatch("gesture with none due", -1, int'(m_tdata));
				end else begin
					due = gestures_due[due_head];
					due_head = (due_head + 1) % DUE_DEPTH;
					due_count--;
					if (m_tdata[1:0] !== due)
						report_mismatch("gesture", int'(due), int'(m_tdata[1:0]));
					if (m_tdata[7:2] !== '0)
						report_mismatch("tdata pad", 0, int'(m_tdata[7:2]));
				end
			end
			gestures_pending <= due_count;
		end
	end

endmodule

@@ test/button_press_classifier_test.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict. The checker beside the block does all prediction.
module button_press_classifier_test;
	import bpc_pkg::*;

	// generous, even for the slowest phases
	localparam int LIMIT = 200000;

	// key value three is legal on the wire and acts like repeat
	localparam logic [KEY_W-1:0] KEY_THREE = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // action, key_value, zero pad
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // gesture, zero pad
	logic               cfg_we;
	logic               cfg_index;
	logic [TIMER_W-1:0] cfg_data;

	int idle_pct;        // sender: chance in 100 of an idle cycle before an item
	int stall_pct;       // receiver: chance in 100 of tready low on a cycle
	int items_sent;
	int pending;         // gestures still due, from the checker
	int failures;
	int cycle_count = 0;

	button_press_classifier uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gesture_checker gesture_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.gestures_pending (pending),
		.mismatch_count   (failures)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// hard stop in case the block hangs or drops an item
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("timeout after %0d cycles, %0d gestures still due", cycle_count, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// Holds tvalid high across back-to-back items; only an idle cycle lowers it,
	// so tvalid never sees two assignments in one step.
	task automatic send_item(input logic act, input logic [KEY_W-1:0] key);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, key, act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// key bits are ignored on a tick, so they get random values there
	task automatic send_ticks(input int n);
		repeat (n)
			send_item(ACT_TICK, KEY_W'($urandom_range(3)));
	endtask

	// wait until every gesture is back, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic set_timers(input logic [TIMER_W-1:0] short_ticks,
			input logic [TIMER_W-1:0] long_ticks);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_SHORT_WINDOW;
		cfg_data <= short_ticks;
		@(posedge clk);
		cfg_index <= REG_LONG_HOLD;
		cfg_data <= long_ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One burst of button activity. sw and lw are the timer lengths clamped
	// to something short enough to walk through with ticks.
	task automatic press_sequence(input int sw, input int lw);
		int kind;
		int pick;
		int taps;
		int tmax;
		int hold;
		kind = $urandom_range(99);
		if (kind < 60) begin
			// taps: mostly single and double, some runs long enough to saturate
			pick = $urandom_range(9);
			taps = (pick < 4) ? 1 : (pick < 7) ? 2 : $urandom_range(3, 18);
			tmax = (taps > 2) ? 1 : sw;
			repeat (taps) begin
				send_item(ACT_KEY, KEY_DOWN);
				repeat ($urandom_range(0, 2))
					send_item(ACT_KEY, ($urandom_range(3) == 0) ? KEY_THREE : KEY_REPEAT);
				hold = $urandom_range(0, tmax);
				if (taps <= 2 && $urandom_range(4) == 0)
					hold = $urandom_range(0, lw);
				send_ticks(hold);
				send_item(ACT_KEY, KEY_UP);
				send_ticks($urandom_range(0, tmax));
			end
			// let the window close
			send_ticks($urandom_range(sw, sw + 2));
		end else if (kind < 80) begin
			// hold down past the long time; repeats only early so the hold can expire
			send_item(ACT_KEY, KEY_DOWN);
			repeat ($urandom_range(0, 2))
				send_item(ACT_KEY, KEY_REPEAT);
			send_ticks(lw + $urandom_range(0, 2));
			send_item(ACT_KEY, KEY_UP);
			send_ticks($urandom_range(0, sw + 1));
		end else begin
			// noise: stray ups, odd key values, ticks in any order
			repeat ($urandom_range(1, 8))
				send_item(1'($urandom_range(1)), KEY_W'($urandom_range(3)));
		end
	endtask

	task automatic run_phase(input logic [TIMER_W-1:0] short_ticks,
			input logic [TIMER_W-1:0] long_ticks, input int send_idle,
			input int recv_stall, input int count);
		int sw;
		int lw;
		int stop;
		set_timers(short_ticks, long_ticks);
		idle_pct = send_idle;
		stall_pct = recv_stall;
		// a timer length of zero acts like one
		sw = (short_ticks == 0) ? 1 : (short_ticks > 12) ? 12 : int'(short_ticks);
		lw = (long_ticks == 0) ? 1 : (long_ticks > 24) ? 24 : int'(long_ticks);
		stop = items_sent + count;
		while (items_sent < stop)
			press_sequence(sw, lw);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SHORT_WINDOW;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: up with nothing pressed, under reset timer values
		send_item(ACT_KEY, KEY_UP);

		set_timers(16'd2, 16'd4);
		// short press
		send_item(ACT_KEY, KEY_DOWN);
		send_item(ACT_KEY, KEY_UP);
		send_ticks(2);
		// double press
		send_item(ACT_KEY, KEY_DOWN);
		send_item(ACT_KEY, KEY_UP);
		send_item(ACT_KEY, KEY_DOWN);
		send_item(ACT_KEY, KEY_UP);
		send_ticks(2);
		// long press; short window runs out while down and just stops
		send_item(ACT_KEY, KEY_DOWN);
		send_ticks(4);
		// window runs out after a repeat: reports even though the key is held
		send_item(ACT_KEY, KEY_DOWN);
		send_item(ACT_KEY, KEY_REPEAT);
		send_ticks(2);
		// key value three counts as a press
		send_item(ACT_KEY, KEY_THREE);
		send_ticks(2);

		// both timers run out on the same tick: long wins
		set_timers(16'd2, 16'd2);
		send_item(ACT_KEY, KEY_DOWN);
		send_ticks(2);

		// random phases: timer settings incl. extremes, every pacing mode
		run_phase(16'd3,     16'd9,     0,  0,  60);
		run_phase(16'd1,     16'd1,     77, 0,  50);
		run_phase(16'd0,     16'd5,     0,  77, 50);
		run_phase(16'd65535, 16'd65535, 9,  9,  40);
		run_phase(16'd5,     16'd3,     0,  0,  50);
		run_phase(16'd4,     16'd12,    77, 0,  50);
		run_phase(16'd6,     16'd6,     0,  77, 50);
		run_phase(16'd2,     16'd20,    9,  9,  50);
		run_phase(16'd65535, 16'd7,     0,  0,  40);
		run_phase(16'd3,     16'd0,     9,  9,  40);
		settle();

		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bpc_pkg.sv
rtl/bpc_step.sv
rtl/button_press_classifier.sv
test/gesture_checker.sv
test/button_press_classifier_test.sv
